@@ sv/matrix_factorization_sgd_update_assert.svh @@
// assertion macros for the factorisation update block
`ifndef MATRIX_FACTORIZATION_SGD_UPDATE_ASSERT_SVH
`define MATRIX_FACTORIZATION_SGD_UPDATE_ASSERT_SVH
`ifndef SYNTHESIS
`define MFS_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define MFS_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define MFS_ASSERT_IMP(label, clk, rst, a, c)
`define MFS_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

@@ sv/mfs_pkg.sv @@
// shared types and constants for the factorisation update block
`default_nettype none
package mfs_pkg;
  localparam int Rank = 16;
  localparam int NumRows = 4096;
  localparam int NumCols = 4096;
  localparam int RankW = (Rank > 1) ? $clog2(Rank) : 1;
  localparam int LAddrW = $clog2(NumRows * Rank);
  localparam int RAddrW = $clog2(NumCols * Rank);

  typedef enum logic [2:0] {
    OP_WR_L = 3'd0, OP_WR_R = 3'd1, OP_RD_L = 3'd2, OP_RD_R = 3'd3,
    OP_TRAIN = 3'd4, OP_PROBE = 3'd5, OP_EPOCH = 3'd6, OP_CLEAR = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    REG_MEAN = 2'd0, REG_MU = 2'd1, REG_STEP = 2'd2, REG_DECAY = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_RDW, S_DOT, S_DOTW, S_RES, S_ERRMUL, S_ERR, S_MUS,
    S_DIV, S_FACT, S_UPD, S_PROBE, S_EPOCH, S_OUT
  } state_t;

  // memory access request from the sequencer
  typedef struct packed {
    logic              l_we;
    logic              r_we;
    logic [LAddrW-1:0] l_addr;
    logic [RAddrW-1:0] r_addr;
    logic [31:0]       l_wdata;
    logic [31:0]       r_wdata;
  } mem_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction
endpackage
`default_nettype wire

@@ sv/mfs_div.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none
module mfs_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [61:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [61:0]      quotient
);
  logic [61:0] q;
  logic [16:0] rem;
  logic [15:0] dv;
  logic [5:0]  cnt;
  logic        busy;
  logic [16:0] trial;
  logic [16:0] shifted;

  assign shifted = {rem[15:0], q[61]};
  assign trial = shifted - {1'b0, dv};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd61;
        q <= dividend;
        rem <= '0;
        dv <= divisor;
      end else if (busy) begin
        if (!trial[16]) begin
          rem <= trial;
          q <= {q[60:0], 1'b1};
        end else begin
          rem <= shifted;
          q <= {q[60:0], 1'b0};
        end
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/mfs_mem.sv @@
// left and right factor memories with registered read data
`default_nettype none
module mfs_mem (
  input  wire logic              clk,
  input  wire mfs_pkg::mem_req_t req,
  output logic [31:0]            l_rdata,
  output logic [31:0]            r_rdata
);
  logic [31:0] lmem [mfs_pkg::NumRows*mfs_pkg::Rank];
  logic [31:0] rmem [mfs_pkg::NumCols*mfs_pkg::Rank];

  always_ff @(posedge clk) begin
    if (req.l_we) lmem[req.l_addr] <= req.l_wdata;
    l_rdata <= lmem[req.l_addr];
  end

  always_ff @(posedge clk) begin
    if (req.r_we) rmem[req.r_addr] <= req.r_wdata;
    r_rdata <= rmem[req.r_addr];
  end
endmodule
`default_nettype wire

@@ sv/matrix_factorization_sgd_update.sv @@
// Factorisation update engine: one input word per command, one output word back.
// Input channel in_valid/in_stall carries opcode and operands; output channel
// out_valid/out_stall returns read_data, residual and probe sums.
// The block takes one word at a time; in_stall is high while it works.
// Probe reads one element pair at a time for the dot product. Train runs the
// dot product, two shrink factor divides through the bit-serial divider, then
// a read-modify-write sweep over both rows.
// Configuration writes go straight into registers; writing initial_step
// also reloads the current step.
// Reset clears step to the initial value, probe sums to zero, registers
// to their reset values; factor memories are undefined until written.
// A stalled result holds on the output ports; no new word is taken until
// the result is delivered.
`default_nettype none
`include "matrix_factorization_sgd_update_assert.svh"
module matrix_factorization_sgd_update (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         opcode,
  input  wire logic [11:0]        entry_row,
  input  wire logic [11:0]        entry_col,
  input  wire logic [3:0]         position,
  input  wire logic signed [31:0] element_value,
  input  wire logic signed [31:0] rating,
  input  wire logic [15:0]        row_degree,
  input  wire logic [15:0]        col_degree,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      read_data,
  output logic signed [31:0]      residual,
  output logic [62:0]             squared_error_sum,
  output logic [31:0]             probe_count
);
  localparam int RW = mfs_pkg::RankW;
  localparam int LW = mfs_pkg::LAddrW;
  localparam int AW = mfs_pkg::RAddrW;

  logic signed [31:0] mean_rating;
  logic [30:0] reg_strength, initial_step;
  logic [24:0] decay_factor;
  logic [31:0] current_step;
  logic [63:0] err_acc;
  logic [31:0] probe_cnt;

  mfs_pkg::state_t state, state_next;
  mfs_pkg::op_t op;
  logic [11:0] row, col;
  logic [3:0]  pos;
  logic signed [31:0] elem, rat;
  logic [15:0] rdeg, cdeg;
  logic [RW:0] k;
  logic signed [63:0] acc;
  logic signed [63:0] prod;
  logic signed [63:0] dot_add, dot_sum;
  logic signed [31:0] res, e, fl, fr;
  logic signed [63:0] p1, p2, p3, p4;
  logic [61:0] mustep;
  logic        div_second;
  logic        div_start, div_done;
  logic [61:0] div_q;
  logic [15:0] div_den;
  logic [31:0] l_rdata, r_rdata;
  mfs_pkg::mem_req_t req;
  logic idx_ok, pos_ok;

  assign idx_ok = (32'(row) < 32'(mfs_pkg::NumRows)) && (32'(col) < 32'(mfs_pkg::NumCols));
  assign pos_ok = 32'(pos) < 32'(mfs_pkg::Rank);

  always_comb begin
    req = '0;
    unique case (state)
      mfs_pkg::S_RD: begin
        req.l_addr = LW'(32'(row) * mfs_pkg::Rank + 32'(pos));
        req.r_addr = AW'(32'(col) * mfs_pkg::Rank + 32'(pos));
        req.l_we = (op == mfs_pkg::OP_WR_L) && pos_ok && idx_ok;
        req.r_we = (op == mfs_pkg::OP_WR_R) && pos_ok && idx_ok;
        req.l_wdata = elem;
        req.r_wdata = elem;
      end
      mfs_pkg::S_DOT: begin
        req.l_addr = LW'(32'(row) * mfs_pkg::Rank + 32'(k));
        req.r_addr = AW'(32'(col) * mfs_pkg::Rank + 32'(k));
      end
      mfs_pkg::S_FACT: begin
        req.l_addr = LW'(32'(row) * mfs_pkg::Rank + 32'(k));
        req.r_addr = AW'(32'(col) * mfs_pkg::Rank + 32'(k));
      end
      mfs_pkg::S_UPD: begin
        req.l_addr = LW'(32'(row) * mfs_pkg::Rank + 32'(k));
        req.r_addr = AW'(32'(col) * mfs_pkg::Rank + 32'(k));
        req.l_we = 1'b1;
        req.r_we = 1'b1;
        req.l_wdata = mfs_pkg::sat32(66'(p1 >>> 24) + 66'(p2 >>> 24));
        req.r_wdata = mfs_pkg::sat32(66'(p3 >>> 24) + 66'(p4 >>> 24));
      end
      default: ;
    endcase
  end

  mfs_mem u_mem (.clk(clk), .req(req), .l_rdata(l_rdata), .r_rdata(r_rdata));

  assign div_den = (state == mfs_pkg::S_DIV) ? ((cdeg == 16'd0) ? 16'd1 : cdeg)
                                             : ((rdeg == 16'd0) ? 16'd1 : rdeg);
  mfs_div u_div (.clk(clk), .rst(rst), .start(div_start), .dividend(mustep),
                 .divisor(div_den), .done(div_done), .quotient(div_q));

  assign in_stall = (state != mfs_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    unique case (state)
      mfs_pkg::S_IDLE: if (in_valid) state_next = mfs_pkg::S_RD;
      mfs_pkg::S_RD: begin
        unique case (op)
          mfs_pkg::OP_TRAIN, mfs_pkg::OP_PROBE:
            state_next = idx_ok ? mfs_pkg::S_DOT : mfs_pkg::S_OUT;
          mfs_pkg::OP_EPOCH: state_next = mfs_pkg::S_EPOCH;
          mfs_pkg::OP_RD_L, mfs_pkg::OP_RD_R: state_next = mfs_pkg::S_RDW;
          default: state_next = mfs_pkg::S_OUT;
        endcase
      end
      mfs_pkg::S_RDW: state_next = mfs_pkg::S_OUT;
      mfs_pkg::S_DOT: state_next = mfs_pkg::S_DOTW;
      mfs_pkg::S_DOTW:
        state_next = (32'(k) == mfs_pkg::Rank) ? mfs_pkg::S_RES : mfs_pkg::S_DOT;
      mfs_pkg::S_RES: state_next = mfs_pkg::S_ERRMUL;
      mfs_pkg::S_ERRMUL:
        state_next = (op == mfs_pkg::OP_TRAIN) ? mfs_pkg::S_ERR : mfs_pkg::S_PROBE;
      mfs_pkg::S_ERR: state_next = mfs_pkg::S_MUS;
      mfs_pkg::S_MUS: begin
        div_start = 1'b1;
        state_next = mfs_pkg::S_DIV;
      end
      mfs_pkg::S_DIV: if (div_done) begin
        if (!div_second) begin
          div_start = 1'b1;
          state_next = mfs_pkg::S_DIV;
        end else begin
          state_next = mfs_pkg::S_FACT;
        end
      end
      mfs_pkg::S_FACT: state_next = mfs_pkg::S_UPD;
      mfs_pkg::S_UPD:
        state_next = (32'(k) == mfs_pkg::Rank - 1) ? mfs_pkg::S_OUT : mfs_pkg::S_FACT;
      mfs_pkg::S_PROBE: state_next = mfs_pkg::S_OUT;
      mfs_pkg::S_EPOCH: state_next = mfs_pkg::S_OUT;
      mfs_pkg::S_OUT: if (!out_stall) state_next = mfs_pkg::S_IDLE;
      default: state_next = mfs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= mfs_pkg::S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_rating <= '0;
      reg_strength <= '0;
      initial_step <= 31'd167772;
      decay_factor <= 25'd16777216;
      current_step <= 32'd167772;
      err_acc <= '0;
      probe_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (mfs_pkg::reg_idx_t'(cfg_index))
          mfs_pkg::REG_MEAN: mean_rating <= cfg_data;
          mfs_pkg::REG_MU: reg_strength <= cfg_data[30:0];
          mfs_pkg::REG_STEP: begin
            initial_step <= cfg_data[30:0];
            current_step <= {1'b0, cfg_data[30:0]};
          end
          mfs_pkg::REG_DECAY: decay_factor <= cfg_data[24:0];
          default: ;
        endcase
      end
      if (state == mfs_pkg::S_EPOCH) begin
        if (prod[63:55] != 9'd0) current_step <= 32'h7fffffff;
        else current_step <= {1'b0, prod[54:24]};
      end
      if (state == mfs_pkg::S_RD && op == mfs_pkg::OP_CLEAR) begin
        err_acc <= '0;
        probe_cnt <= '0;
      end
      if (state == mfs_pkg::S_PROBE) begin
        if (err_acc + prod > 64'h7fffffffffffffff) err_acc <= 64'h7fffffffffffffff;
        else err_acc <= err_acc + prod;
        if (probe_cnt != 32'hffffffff) probe_cnt <= probe_cnt + 32'd1;
      end
      if (state_next == mfs_pkg::S_OUT && state != mfs_pkg::S_OUT) out_valid <= 1'b1;
      else if (state == mfs_pkg::S_OUT && !out_stall) out_valid <= 1'b0;
    end
  end

  assign dot_add = acc + prod;
  assign dot_sum = ((acc[63] == prod[63]) && (dot_add[63] != acc[63]))
                   ? (acc[63] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff)
                   : dot_add;

  always_ff @(posedge clk) begin
    unique case (state)
      mfs_pkg::S_IDLE: if (in_valid) begin
        op <= mfs_pkg::op_t'(opcode);
        row <= entry_row;
        col <= entry_col;
        pos <= position;
        elem <= element_value;
        rat <= rating;
        rdeg <= row_degree;
        cdeg <= col_degree;
        k <= '0;
        acc <= '0;
        res <= '0;
        read_data <= '0;
        div_second <= 1'b0;
      end
      mfs_pkg::S_RD: if (op == mfs_pkg::OP_EPOCH)
        prod <= $signed({32'd0, current_step}) * $signed({39'd0, decay_factor});
      mfs_pkg::S_RDW:
        if (pos_ok && idx_ok)
          read_data <= (op == mfs_pkg::OP_RD_L) ? l_rdata : r_rdata;
      mfs_pkg::S_DOT: k <= k + 1'b1;
      mfs_pkg::S_DOTW: prod <= $signed(l_rdata) * $signed(r_rdata);
      default: ;
    endcase
    // accumulate previous product one state behind
    if (state == mfs_pkg::S_DOT && k != '0) acc <= dot_sum;
    if (state == mfs_pkg::S_RES)
      res <= mfs_pkg::sat32((66'(dot_sum) >>> 24) + 66'(mean_rating) - 66'(rat));
    if (state == mfs_pkg::S_ERRMUL)
      prod <= (op == mfs_pkg::OP_PROBE) ? 64'(res) * 64'(res)
                                        : $signed({32'd0, current_step}) * 64'(res);
    if (state == mfs_pkg::S_ERR) begin
      e <= mfs_pkg::sat32(-(66'(prod >>> 24)));
      mustep <= reg_strength * current_step[30:0];
    end
    if (state == mfs_pkg::S_DIV && div_done) begin
      if (!div_second) begin
        fl <= mfs_pkg::sat32(66'sd16777216 - 66'(div_q >> 24));
        div_second <= 1'b1;
      end else begin
        fr <= mfs_pkg::sat32(66'sd16777216 - 66'(div_q >> 24));
      end
    end
    if (state == mfs_pkg::S_RES) k <= '0;
    if (state == mfs_pkg::S_UPD) k <= k + 1'b1;
    if (state_next == mfs_pkg::S_OUT && state != mfs_pkg::S_OUT)
      residual <= (state == mfs_pkg::S_UPD || state == mfs_pkg::S_PROBE) ? res : '0;
  end

  always_comb begin
    p1 = $signed(l_rdata) * fl;
    p2 = $signed(r_rdata) * e;
    p3 = $signed(r_rdata) * fr;
    p4 = $signed(l_rdata) * e;
  end

  assign squared_error_sum = err_acc[62:0];
  assign probe_count = probe_cnt;

  `MFS_ASSERT_IMP(a_stall_busy, clk, rst, state != mfs_pkg::S_IDLE, in_stall)
  `MFS_ASSERT_IMP(a_out_state, clk, rst, out_valid, state == mfs_pkg::S_OUT)
  `MFS_ASSERT_NXT(a_out_done, clk, rst, out_valid && !out_stall, !out_valid)
endmodule
`default_nettype wire

@@ verif/matrix_factorization_sgd_update_checker.sv @@
// checker for the factorisation update block: predicts each result word and compares
`default_nettype none
module matrix_factorization_sgd_update_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [2:0]         opcode,
  input  wire logic [11:0]        entry_row,
  input  wire logic [11:0]        entry_col,
  input  wire logic [3:0]         position,
  input  wire logic signed [31:0] element_value,
  input  wire logic signed [31:0] rating,
  input  wire logic [15:0]        row_degree,
  input  wire logic [15:0]        col_degree,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [31:0] read_data,
  input  wire logic signed [31:0] residual,
  input  wire logic [62:0]        squared_error_sum,
  input  wire logic [31:0]        probe_count,
  output int                      fails,
  output int                      outstanding
);

  localparam longint OneQ24 = 64'sd16777216;
  localparam longint MaxQ = 64'sd2147483647;
  localparam longint MaxSum = 64'sh7fffffffffffffff;

  typedef struct {
    logic signed [31:0] rdata;
    logic signed [31:0] resid;
    logic [62:0]        sq_sum;
    logic [31:0]        count;
  } result_t;

  logic signed [31:0] left_mem [0:65535];
  logic signed [31:0] right_mem [0:65535];
  longint mean_q, mu_q, step_q, decay_q, err_sum, probes;
  result_t pending_q [$];

  function automatic longint clamp32(input longint x);
    if (x > MaxQ) return MaxQ;
    if (x < -MaxQ - 1) return -MaxQ - 1;
    return x;
  endfunction

  function automatic longint dot_residual(input int row, input int col, input longint rt);
    longint acc;
    logic signed [64:0] s;
    acc = 0;
    for (int k = 0; k < mfs_pkg::Rank; k++) begin
      s = 65'(acc) + 65'(longint'(left_mem[row*mfs_pkg::Rank+k]) *
                         longint'(right_mem[col*mfs_pkg::Rank+k]));
      if (s > 65'(MaxSum)) acc = MaxSum;
      else if (s < -65'(MaxSum) - 1) acc = -MaxSum - 1;
      else acc = longint'(s);
    end
    return clamp32((acc >>> 24) + mean_q - rt);
  endfunction

  function automatic longint shrink(input longint deg);
    longint unsigned q;
    q = longint'(mu_q * step_q) / longint'(deg == 0 ? 1 : deg);
    return clamp32(OneQ24 - longint'(q >> 24));
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fails++;
  endtask

  task automatic predict_word();
    result_t r;
    int row, col, adr;
    longint res, e, fl, fr, lo, ro, sq;
    row = int'(entry_row);
    col = int'(entry_col);
    adr = int'(position);
    res = 0;
    r.rdata = 0;
    case (mfs_pkg::op_t'(opcode))
      mfs_pkg::OP_WR_L: left_mem[row*mfs_pkg::Rank+adr] = element_value;
      mfs_pkg::OP_WR_R: right_mem[col*mfs_pkg::Rank+adr] = element_value;
      mfs_pkg::OP_RD_L: r.rdata = left_mem[row*mfs_pkg::Rank+adr];
      mfs_pkg::OP_RD_R: r.rdata = right_mem[col*mfs_pkg::Rank+adr];
      mfs_pkg::OP_TRAIN: begin
        res = dot_residual(row, col, longint'(rating));
        e = clamp32(-((step_q * res) >>> 24));
        fl = shrink(longint'(row_degree));
        fr = shrink(longint'(col_degree));
        for (int k = 0; k < mfs_pkg::Rank; k++) begin
          lo = left_mem[row*mfs_pkg::Rank+k];
          ro = right_mem[col*mfs_pkg::Rank+k];
          left_mem[row*mfs_pkg::Rank+k] =
            32'(clamp32(((lo * fl) >>> 24) + ((ro * e) >>> 24)));
          right_mem[col*mfs_pkg::Rank+k] =
            32'(clamp32(((ro * fr) >>> 24) + ((lo * e) >>> 24)));
        end
      end
      mfs_pkg::OP_PROBE: begin
        res = dot_residual(row, col, longint'(rating));
        sq = res * res;
        if (err_sum > MaxSum - sq) err_sum = MaxSum;
        else err_sum += sq;
        if (probes != 64'hffffffff) probes++;
      end
      mfs_pkg::OP_EPOCH: begin
        step_q = (step_q * decay_q) >>> 24;
        if (step_q > MaxQ) step_q = MaxQ;
      end
      default: begin
        err_sum = 0;
        probes = 0;
      end
    endcase
    r.resid = 32'(res);
    r.sq_sum = 63'(err_sum);
    r.count = 32'(probes);
    pending_q.push_back(r);
  endtask

  always @(posedge clk) begin
    result_t w;
    if (rst) begin
      mean_q = 0;
      mu_q = 0;
      step_q = 167772;
      decay_q = OneQ24;
      err_sum = 0;
      probes = 0;
      pending_q.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        case (mfs_pkg::reg_idx_t'(cfg_index))
          mfs_pkg::REG_MEAN: mean_q = longint'(signed'(cfg_data));
          mfs_pkg::REG_MU: mu_q = longint'(cfg_data[30:0]);
          mfs_pkg::REG_STEP: step_q = longint'(cfg_data[30:0]);
          default: decay_q = longint'(cfg_data[24:0]);
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          report("unexpected word", 0, 0);
        end else begin
          w = pending_q.pop_front();
          if (read_data !== w.rdata) report("read_data", read_data, w.rdata);
          if (residual !== w.resid) report("residual", residual, w.resid);
          if (squared_error_sum !== w.sq_sum)
            report("squared_error_sum", squared_error_sum, w.sq_sum);
          if (probe_count !== w.count) report("probe_count", probe_count, w.count);
        end
      end
      if (in_valid && !in_stall) predict_word();
    end
    outstanding = pending_q.size();
  end

endmodule
`default_nettype wire

@@ verif/matrix_factorization_sgd_update_test.sv @@
// testbench top for the factorisation update block: stimulus, stalls and verdict
`default_nettype none
module matrix_factorization_sgd_update_test;

  localparam int WatchLimit = 5000;

  logic clk, rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [2:0] opcode;
  logic [11:0] entry_row, entry_col;
  logic [3:0] position;
  logic signed [31:0] element_value, rating, read_data, residual;
  logic [15:0] row_degree, col_degree;
  logic [62:0] squared_error_sum;
  logic [31:0] probe_count;
  int fails, outstanding;

  bit l_written [0:65535];
  bit r_written [0:65535];
  int pool_l [6];
  int pool_r [6];
  int burst_left, idle_cycles, stall_run, rx_mode, rx_timer;

  matrix_factorization_sgd_update u_dut (.*);
  matrix_factorization_sgd_update_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // receiver stall pattern: a periodically redrawn mode picks no stall, random stalls or stall runs
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      stall_run = 0;
      rx_mode = 0;
      rx_timer = 0;
    end else begin
      if (++rx_timer == 300) begin
        rx_timer = 0;
        rx_mode = $urandom_range(0, 2);
      end
      if (stall_run > 0) begin
        stall_run--;
        out_stall <= 1;
      end else if (rx_mode == 1) begin
        out_stall <= ($urandom_range(0, 9) < 3);
      end else if (rx_mode == 2 && $urandom_range(0, 7) == 0) begin
        stall_run = $urandom_range(1, 30);
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= WatchLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] small_q();
    return 32'($urandom_range(0, 1 << 26)) - 32'(1 << 25);
  endfunction

  function automatic logic [31:0] any_q();
    return ($urandom_range(0, 4) == 0) ? $urandom : small_q();
  endfunction

  function automatic logic [15:0] any_deg();
    return ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_word(input mfs_pkg::op_t op, input int row, input int col,
                           input int pos, input logic [31:0] elem, input logic [31:0] rt,
                           input logic [15:0] rdeg, input logic [15:0] cdeg);
    if (burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    opcode <= op;
    entry_row <= 12'(row);
    entry_col <= 12'(col);
    position <= 4'(pos);
    element_value <= elem;
    rating <= rt;
    row_degree <= rdeg;
    col_degree <= cdeg;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    if (op == mfs_pkg::OP_WR_L) l_written[row*mfs_pkg::Rank+pos] = 1;
    if (op == mfs_pkg::OP_WR_R) r_written[col*mfs_pkg::Rank+pos] = 1;
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_regs(input logic [31:0] mean, input logic [31:0] mu,
                           input logic [31:0] step, input logic [31:0] decay);
    cfg_we <= 1;
    cfg_index <= mfs_pkg::REG_MEAN;
    cfg_data <= mean;
    @(posedge clk);
    cfg_index <= mfs_pkg::REG_MU;
    cfg_data <= mu;
    @(posedge clk);
    cfg_index <= mfs_pkg::REG_STEP;
    cfg_data <= step;
    @(posedge clk);
    cfg_index <= mfs_pkg::REG_DECAY;
    cfg_data <= decay;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic random_words(input int n);
    int r, row, col, pos, k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      row = pool_l[$urandom_range(0, 5)];
      col = pool_r[$urandom_range(0, 5)];
      pos = $urandom_range(0, mfs_pkg::Rank - 1);
      if (r < 10) begin
        if ($urandom_range(0, 1)) row = $urandom_range(0, mfs_pkg::NumRows - 1);
        send_word(mfs_pkg::OP_WR_L, row, $urandom, pos, any_q(), $urandom, $urandom,
                  $urandom);
      end else if (r < 20) begin
        if ($urandom_range(0, 1)) col = $urandom_range(0, mfs_pkg::NumCols - 1);
        send_word(mfs_pkg::OP_WR_R, $urandom, col, pos, any_q(), $urandom, $urandom,
                  $urandom);
      end else if (r < 30) begin
        k = $urandom_range(0, 65535);
        if (!l_written[k]) k = row * mfs_pkg::Rank + pos;
        send_word(mfs_pkg::OP_RD_L, k / mfs_pkg::Rank, $urandom, k % mfs_pkg::Rank,
                  $urandom, $urandom, $urandom, $urandom);
      end else if (r < 40) begin
        k = $urandom_range(0, 65535);
        if (!r_written[k]) k = col * mfs_pkg::Rank + pos;
        send_word(mfs_pkg::OP_RD_R, $urandom, k / mfs_pkg::Rank, k % mfs_pkg::Rank,
                  $urandom, $urandom, $urandom, $urandom);
      end else if (r < 75) begin
        send_word(mfs_pkg::OP_TRAIN, row, col, $urandom, $urandom, any_q(), any_deg(),
                  any_deg());
      end else if (r < 90) begin
        send_word(mfs_pkg::OP_PROBE, row, col, $urandom, $urandom, any_q(), $urandom,
                  $urandom);
      end else if (r < 95) begin
        send_word(mfs_pkg::OP_EPOCH, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
      end else begin
        send_word(mfs_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
      end
      if ($urandom_range(0, 199) == 0) drain();
    end
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = mfs_pkg::REG_MEAN;
    cfg_data = 0;
    in_valid = 0;
    opcode = mfs_pkg::OP_WR_L;
    entry_row = 0;
    entry_col = 0;
    position = 0;
    element_value = 0;
    rating = 0;
    row_degree = 0;
    col_degree = 0;
    burst_left = 0;
    pool_l = '{0, 4095, 2730, 1365, 0, 0};
    pool_r = '{0, 4095, 1365, 2730, 0, 0};
    pool_l[4] = $urandom_range(1, 4094);
    pool_l[5] = $urandom_range(1, 4094);
    pool_r[4] = $urandom_range(1, 4094);
    pool_r[5] = $urandom_range(1, 4094);
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // fill the working rows so every train and probe sees written elements
    foreach (pool_l[i])
      for (int k = 0; k < mfs_pkg::Rank; k++) begin
        send_word(mfs_pkg::OP_WR_L, pool_l[i], $urandom, k, small_q(), 0, 0, 0);
        send_word(mfs_pkg::OP_WR_R, $urandom, pool_r[i], k, small_q(), 0, 0, 0);
      end

    // directed: extreme elements, read back, saturating train, every opcode
    send_word(mfs_pkg::OP_WR_L, 4095, 0, 15, 32'h7fffffff, 0, 0, 0);
    send_word(mfs_pkg::OP_WR_R, 0, 4095, 0, 32'h80000000, 0, 0, 0);
    send_word(mfs_pkg::OP_WR_L, 4095, 0, 0, 32'h7fffffff, 0, 0, 0);
    send_word(mfs_pkg::OP_WR_R, 0, 4095, 15, 32'h7fffffff, 0, 0, 0);
    send_word(mfs_pkg::OP_RD_L, 4095, 0, 15, 0, 0, 0, 0);
    send_word(mfs_pkg::OP_RD_R, 0, 4095, 0, 0, 0, 0, 0);
    send_word(mfs_pkg::OP_RD_L, 0, 0, 0, 0, 0, 0, 0);
    send_word(mfs_pkg::OP_PROBE, 4095, 4095, 0, 0, 32'h80000000, 0, 0);
    send_word(mfs_pkg::OP_PROBE, 4095, 4095, 0, 0, 32'h7fffffff, 0, 0);
    send_word(mfs_pkg::OP_TRAIN, 4095, 4095, 0, 0, 32'h80000000, 16'd0, 16'hffff);
    send_word(mfs_pkg::OP_TRAIN, 0, 0, 0, 0, 32'h7fffffff, 16'hffff, 16'd0);
    send_word(mfs_pkg::OP_TRAIN, 1365, 2730, 0, 0, 0, 16'd1, 16'd1);
    send_word(mfs_pkg::OP_RD_L, 4095, 0, 15, 0, 0, 0, 0);
    send_word(mfs_pkg::OP_RD_R, 0, 4095, 15, 0, 0, 0, 0);
    send_word(mfs_pkg::OP_EPOCH, 0, 0, 0, 0, 0, 0, 0);
    send_word(mfs_pkg::OP_PROBE, 0, 0, 0, 0, 0, 0, 0);
    send_word(mfs_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    send_word(mfs_pkg::OP_PROBE, 2730, 1365, 0, 0, 32'h01000000, 0, 0);
    drain();

    random_words(280);
    drain();
    load_regs(small_q(), 32'd1 << 20, 32'd1 << 22, 32'd8388608);
    random_words(280);
    drain();
    load_regs(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'd0);
    random_words(280);
    drain();
    load_regs(32'h7fffffff, 32'd0, 32'd0, 32'd16777216);
    random_words(280);
    drain();
    load_regs($urandom, $urandom, $urandom, $urandom_range(0, 16777216));
    random_words(280);

    drain();
    repeat (300) @(posedge clk);
    if (fails == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
